[rtl/wspbe_pkg.sv]
// Package for the WS2812 pixel bit encoder: shared types, codes and constants.
// Used by every module of the block but the RAM; depends on nothing else.
package wspbe_pkg;

  // Geometry of the gamma table, of one pixel and latch run, and of the job queue.
  localparam int GammaDepth      = 256;
  localparam int SymbolsPerPixel = 24;
  localparam int MaxSlots        = 64;
  localparam int DefQueueDepth   = 2;

  // Register reset values.
  localparam logic [7:0] DutyZeroRst   = 8'd18;
  localparam logic [7:0] DutyOneRst    = 8'd37;
  localparam logic [7:0] FactorRst     = 8'd50;
  localparam logic [6:0] ResetSlotsRst = 7'd48;

  // Input item kinds, carried on tuser.
  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_PIXEL = 2'd1,
    ACT_EOF   = 2'd2
  } action_e;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_DUTY_ZERO   = 2'd0,
    REG_DUTY_ONE    = 2'd1,
    REG_FACTOR      = 2'd2,
    REG_RESET_SLOTS = 2'd3
  } reg_idx_e;

  // Front-end sequencer states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_PUSH
  } front_state_e;

  // Configuration as seen by the front and back parts.
  typedef struct packed {
    logic [7:0] duty_zero;
    logic [7:0] duty_one;
    logic [7:0] factor;
    logic [6:0] reset_slots;
  } cfg_t;

  // One queued job: a 24-bit pixel word, or a latch slot count in the low bits.
  typedef struct packed {
    logic        is_pixel;
    logic [23:0] payload;
  } entry_t;

  // Gamma table access from the front part.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } ram_req_t;

endpackage

[rtl/wspbe_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module wspbe_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/wspbe_front.sv]
// Front part: accepts items, writes the gamma table, corrects and scales pixels
// and hands jobs to the queue. Depends on wspbe_pkg.
module wspbe_front
  import wspbe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0]  in_action_i,
  input  logic [39:0] in_data_i,
  output ram_req_t ram_req_o,
  input  logic [7:0]  ram_rdata_i,
  output logic     push_o,
  output entry_t   entry_o,
  input  logic     full_i
);

  front_state_e state_q, state_d;
  logic [2:0]   rcnt_q, rcnt_d;
  logic [7:0]   chan_q [3];
  logic [15:0]  prod_q;
  logic         is_pixel_q;
  logic [23:0]  payload_q;

  logic         accept;
  action_e      action;
  logic [16:0]  quot_sum;
  logic [7:0]   quot;
  logic [6:0]   slots;
  logic         read_done;

  assign action    = action_e'(in_action_i);
  assign accept    = in_valid_i && in_ready_o;
  assign read_done = (rcnt_q == 3'd4);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE, F_PUSH: begin
        if (state_q == F_IDLE || !full_i) begin
          state_d = F_IDLE;
          if (accept) begin
            priority case (action)
              ACT_PIXEL: state_d = F_READ;
              ACT_EOF:   state_d = F_PUSH;
              default:   state_d = F_IDLE;
            endcase
          end
        end
      end
      F_READ: begin
        if (read_done) state_d = F_PUSH;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: in_ready_o = 1'b1;
      F_PUSH: begin
        in_ready_o = !full_i;
        push_o     = !full_i;
      end
      F_READ: in_ready_o = 1'b0;
      default: in_ready_o = 1'b0;
    endcase
  end

  // Gamma table: loads write at acceptance, pixels read one channel a cycle.
  always_comb begin
    ram_req_o.we    = accept && (action == ACT_LOAD);
    ram_req_o.waddr = in_data_i[7:0];
    ram_req_o.wdata = in_data_i[15:8];
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = chan_q[0];
    if (state_q == F_READ) begin
      unique case (rcnt_q)
        3'd0: begin ram_req_o.re = 1'b1; ram_req_o.raddr = chan_q[0]; end
        3'd1: begin ram_req_o.re = 1'b1; ram_req_o.raddr = chan_q[1]; end
        3'd2: begin ram_req_o.re = 1'b1; ram_req_o.raddr = chan_q[2]; end
        default: ram_req_o.re = 1'b0;
      endcase
    end
  end

  // floor(x / 255) for a 16-bit product: (x + (x >> 8) + 1) >> 8.
  assign quot_sum = {1'b0, prod_q} + {9'd0, prod_q[15:8]} + 17'd1;
  assign quot     = quot_sum[15:8];

  // Latch slot count, clamped to 1..MaxSlots.
  always_comb begin
    if (cfg_i.reset_slots == 7'd0) begin
      slots = 7'd1;
    end else if (cfg_i.reset_slots > 7'(MaxSlots)) begin
      slots = 7'(MaxSlots);
    end else begin
      slots = cfg_i.reset_slots;
    end
  end

  // Channel step counter.
  always_comb begin
    rcnt_d = rcnt_q;
    if (accept) begin
      rcnt_d = 3'd0;
    end else if (state_q == F_READ && !read_done) begin
      rcnt_d = rcnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      rcnt_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
    end
  end

  // Datapath: capture channels, multiply, then divide and shift into the word.
  always_ff @(posedge clk_i) begin
    if (accept && action == ACT_PIXEL) begin
      chan_q[0]  <= in_data_i[23:16];
      chan_q[1]  <= in_data_i[31:24];
      chan_q[2]  <= in_data_i[39:32];
      is_pixel_q <= 1'b1;
    end
    if (accept && action == ACT_EOF) begin
      is_pixel_q <= 1'b0;
      payload_q  <= {17'd0, slots};
    end
    if (state_q == F_READ && rcnt_q >= 3'd1 && rcnt_q <= 3'd3) begin
      prod_q <= 16'(ram_rdata_i) * 16'(cfg_i.factor);
    end
    if (state_q == F_READ && rcnt_q >= 3'd2) begin
      payload_q <= {payload_q[15:0], quot};
    end
  end

  assign entry_o.is_pixel = is_pixel_q;
  assign entry_o.payload  = payload_q;

endmodule

[rtl/wspbe_queue.sv]
// Short job queue between the front and back parts, held in flip-flops.
// Depends on wspbe_pkg for the entry type.
module wspbe_queue
  import wspbe_pkg::*;
#(
  parameter int Depth = DefQueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o,
  output logic   full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

[rtl/wspbe_back.sv]
// Back part: turns queued jobs into one duty symbol a cycle, unless the output stalls,
// behind an output register. Depends on wspbe_pkg.
module wspbe_back
  import wspbe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  entry_t     head_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_duty_o,
  output logic       out_last_o
);

  logic        busy_q, busy_d;
  logic        is_pixel_q;
  logic [23:0] shift_q;
  logic [6:0]  remain_q;
  logic        valid_q, valid_d;
  logic [7:0]  duty_q, duty_d;
  logic        last_q, last_d;

  logic        advance;
  logic        src_valid;
  logic        src_pixel;
  logic [23:0] src_shift;
  logic [6:0]  src_remain;

  assign advance = !valid_q || out_ready_i;

  // Symbol source: the run in progress, else the queue head.
  always_comb begin
    if (busy_q) begin
      src_valid  = 1'b1;
      src_pixel  = is_pixel_q;
      src_shift  = shift_q;
      src_remain = remain_q;
    end else begin
      src_valid  = !empty_i;
      src_pixel  = head_i.is_pixel;
      src_shift  = head_i.payload;
      src_remain = head_i.is_pixel ? 7'(SymbolsPerPixel) : head_i.payload[6:0];
    end
  end

  assign pop_o = advance && !busy_q && !empty_i;

  // Next symbol and run bookkeeping.
  always_comb begin
    valid_d = valid_q;
    duty_d  = duty_q;
    last_d  = last_q;
    busy_d  = busy_q;
    if (advance) begin
      valid_d = src_valid;
      duty_d  = !src_pixel ? 8'd0 : (src_shift[23] ? cfg_i.duty_one : cfg_i.duty_zero);
      last_d  = (src_remain == 7'd1);
      busy_d  = src_valid && (src_remain != 7'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q <= duty_d;
    last_q <= last_d;
    if (advance && src_valid) begin
      is_pixel_q <= src_pixel;
      shift_q    <= {src_shift[22:0], 1'b0};
      remain_q   <= src_remain - 7'd1;
    end
  end

  assign out_valid_o = valid_q;
  assign out_duty_o  = duty_q;
  assign out_last_o  = last_q;

endmodule

[rtl/ws2812_pixel_bit_encoder.sv]
// WS2812 pixel bit encoder. In the front a pixel goes from its transfer to its push
// through three reads of the single-read-port gamma RAM, a multiply, a divide and the
// push, and the next item can be taken while it is pushed. The back emits one symbol a
// cycle unless the output stalls: 24 for a pixel and reset_slots, clamped to 1..64,
// for an end of frame. Reset clears control state and loads register defaults; the
// gamma table is undefined until written and gets no clearing pass.
module ws2812_pixel_bit_encoder
  import wspbe_pkg::*;
#(
  parameter int QueueDepth = DefQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // gamma_addr, gamma_value, red, green, blue
  input  logic [1:0]  s_axis_tuser,  // action
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // duty
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_q;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;
  logic     push, pop, q_empty, q_full;
  entry_t   entry, head;
  reg_idx_e reg_idx;
  logic     cfg_we;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_zero   <= DutyZeroRst;
      cfg_q.duty_one    <= DutyOneRst;
      cfg_q.factor      <= FactorRst;
      cfg_q.reset_slots <= ResetSlotsRst;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_DUTY_ZERO:   cfg_q.duty_zero   <= pwdata[7:0];
        REG_DUTY_ONE:    cfg_q.duty_one    <= pwdata[7:0];
        REG_FACTOR:      cfg_q.factor      <= pwdata[7:0];
        REG_RESET_SLOTS: cfg_q.reset_slots <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_DUTY_ZERO:   prdata = {24'd0, cfg_q.duty_zero};
      REG_DUTY_ONE:    prdata = {24'd0, cfg_q.duty_one};
      REG_FACTOR:      prdata = {24'd0, cfg_q.factor};
      REG_RESET_SLOTS: prdata = {25'd0, cfg_q.reset_slots};
      default:         prdata = 32'd0;
    endcase
  end

  // Front part.
  wspbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .push_o      (push),
    .entry_o     (entry),
    .full_i      (q_full)
  );

  // Gamma table.
  wspbe_ram #(
    .Width (8),
    .Depth (GammaDepth)
  ) u_gamma_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  // Job queue.
  wspbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Back part.
  wspbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_duty_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // The front never pushes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("job pushed into a full queue");

  // The back never pops an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_empty)
    else $error("job popped from an empty queue");

  // A table load never collides with a pixel's channel reads.
  assert property (@(posedge clk_i) disable iff (!rst_ni) ram_req.we |-> !ram_req.re)
    else $error("gamma write during a pixel read");

  // A load transfer leaves the front ready for the next item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_LOAD) |=> s_axis_tready)
    else $error("front stalled after a table load");

endmodule
